>>> src/ddo_pkg.sv
// Package with the shared widths, constants and the CORDIC angle table.
package ddo_pkg;
  localparam int CordicStages = 16;
  localparam int AtanLen = 24;
  localparam int NStages = (CordicStages > AtanLen) ? AtanLen : CordicStages;
  localparam int StepW = $clog2(NStages + 1);
  localparam int CntW = 32;
  localparam int PosW = 48;
  localparam int AngW = 16;
  localparam int WbW = 16;
  localparam int CrW = 60;
  localparam logic [WbW-1:0] WheelBaseReset = 16'd408;
  localparam logic signed [CrW-1:0] GainQ30 = 60'sd652032874;

  typedef logic [33:0] atan_t;

  function automatic atan_t atan_lookup(input logic [StepW-1:0] idx);
    atan_t v;
    begin
      case (idx)
        0: v = 34'h020000000;
        1: v = 34'h012E4051E;
        2: v = 34'h009FB385B;
        3: v = 34'h0051111D4;
        4: v = 34'h0028B0D43;
        5: v = 34'h00145D7E1;
        6: v = 34'h000A2F61E;
        7: v = 34'h000517C55;
        8: v = 34'h00028BE53;
        9: v = 34'h000145F2F;
        10: v = 34'h0000A2F98;
        11: v = 34'h0000517CC;
        12: v = 34'h000028BE6;
        13: v = 34'h0000145F3;
        14: v = 34'h00000A2FA;
        15: v = 34'h00000517D;
        16: v = 34'h0000028BE;
        17: v = 34'h00000145F;
        18: v = 34'h000000A30;
        19: v = 34'h000000518;
        20: v = 34'h00000028C;
        21: v = 34'h000000146;
        22: v = 34'h0000000A3;
        23: v = 34'h000000051;
        default: v = '0;
      endcase
      return v;
    end
  endfunction
endpackage

>>> src/ddo_if.sv
// Valid/ready channel interfaces for input samples and pose results.
interface ddo_in_if;
  logic valid;
  logic ready;
  logic signed [31:0] left_count;
  logic signed [31:0] right_count;
  modport source (output valid, left_count, right_count, input ready);
  modport sink (input valid, left_count, right_count, output ready);
endinterface

interface ddo_out_if;
  logic valid;
  logic ready;
  logic signed [47:0] pos_x;
  logic signed [47:0] pos_y;
  logic [15:0] heading;
  modport source (output valid, pos_x, pos_y, heading, input ready);
  modport sink (input valid, pos_x, pos_y, heading, output ready);
endinterface

>>> src/ddo_cordic.sv
// Shared iterative CORDIC unit for rotation and vectoring, one stage a cycle.
module ddo_cordic
  import ddo_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  logic vector_mode,
  input  logic signed [CrW-1:0] x_init,
  input  logic signed [CrW-1:0] y_init,
  input  logic signed [CrW-1:0] z_init,
  output logic done,
  output logic signed [CrW-1:0] x_out,
  output logic signed [CrW-1:0] y_out,
  output logic signed [CrW-1:0] z_out
);
  logic busy;
  logic mode;
  logic [StepW-1:0] step;
  logic signed [CrW-1:0] xs, ys, ang;
  logic dir;

  assign xs = x_out >>> step;
  assign ys = y_out >>> step;
  assign ang = CrW'(signed'({1'b0, atan_lookup(step)}));
  assign dir = mode ? (y_out >= 0) : (z_out >= 0);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
      mode <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
        mode <= vector_mode;
        x_out <= x_init;
        y_out <= y_init;
        z_out <= z_init;
      end else if (busy) begin
        if (mode) begin
          if (dir) begin
            x_out <= x_out + ys;
            y_out <= y_out - xs;
            z_out <= z_out + ang;
          end else begin
            x_out <= x_out - ys;
            y_out <= y_out + xs;
            z_out <= z_out - ang;
          end
        end else begin
          if (dir) begin
            x_out <= x_out - ys;
            y_out <= y_out + xs;
            z_out <= z_out - ang;
          end else begin
            x_out <= x_out + ys;
            y_out <= y_out - xs;
            z_out <= z_out + ang;
          end
        end
        if (step == StepW'(NStages - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          step <= step + 1'b1;
        end
      end
    end
  end
endmodule

>>> src/differential_drive_odometry.sv
// Top level of the differential drive odometry block.
//   channel  dir  words
//   in       in   left_count, right_count
//   out      out  pos_x, pos_y, heading
//   cfg      in   wheel_base_steps write
// One word is taken at a time: the next accept waits until the last result has gone.
// After the accept the word runs through S_ROT, S_MUL, S_ADD and S_VEC; the result is offered in S_OUT.
// The rotation pass and the vectoring pass run one after the other on the same unit.
// Reset clears the pose, the last counts and the wheel base to 408.
// A result waiting on the output holds the block; a new word is taken once it is gone.
module differential_drive_odometry
  import ddo_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic cfg_we,
  input  logic [WbW-1:0] cfg_data,
  ddo_in_if.sink in_ch,
  ddo_out_if.source out_ch
);
  typedef enum logic [2:0] {
    S_IDLE, S_ROT, S_MUL, S_ADD, S_VEC, S_OUT
  } state_t;

  state_t state;
  logic [WbW-1:0] wheel_base;
  logic [CntW-1:0] last_left, last_right;
  logic [PosW-1:0] acc_x, acc_y;
  logic [AngW-1:0] acc_heading;
  logic signed [32:0] travel, diff;
  logic [1:0] quad;
  logic cor_start, cor_vec, cor_done;
  logic signed [CrW-1:0] cx_init, cy_init, cz_init, cx, cy, cz;
  logic signed [CrW-1:0] cq, sq;
  logic signed [63:0] px, py;
  logic signed [CntW-1:0] dl, dr;
  logic signed [32:0] sum;
  logic [AngW-1:0] hq;
  logic signed [AngW-1:0] res;
  logic signed [CrW-1:0] zr;

  assign dl = signed'(in_ch.left_count - last_left);
  assign dr = signed'(in_ch.right_count - last_right);
  assign sum = 33'(dl) + 33'(dr);
  assign hq = acc_heading + 16'd8192;
  assign res = signed'(acc_heading - {hq[15:14], 14'd0});

  always_comb begin
    unique case (quad)
      2'd0: begin cq = cx; sq = cy; end
      2'd1: begin cq = -cy; sq = cx; end
      2'd2: begin cq = -cx; sq = -cy; end
      default: begin cq = cy; sq = -cx; end
    endcase
  end

  always_comb begin
    if (state == S_IDLE) begin
      cor_vec = 1'b0;
      cx_init = GainQ30;
      cy_init = '0;
      cz_init = CrW'(res) <<< 16;
    end else begin
      cor_vec = 1'b1;
      cx_init = CrW'({1'b0, wheel_base}) <<< 24;
      cy_init = CrW'(diff) <<< 24;
      cz_init = '0;
    end
  end

  assign cor_start = (state == S_IDLE && in_ch.valid) || state == S_ADD;
  assign zr = cz + CrW'(32768);
  assign in_ch.ready = state == S_IDLE;
  assign out_ch.valid = state == S_OUT;
  assign out_ch.pos_x = signed'(acc_x);
  assign out_ch.pos_y = signed'(acc_y);
  assign out_ch.heading = acc_heading;

  ddo_cordic u_cordic (
    .clk(clk), .rst(rst), .start(cor_start), .vector_mode(cor_vec),
    .x_init(cx_init), .y_init(cy_init), .z_init(cz_init),
    .done(cor_done), .x_out(cx), .y_out(cy), .z_out(cz)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      wheel_base <= WheelBaseReset;
      last_left <= '0;
      last_right <= '0;
      acc_x <= '0;
      acc_y <= '0;
      acc_heading <= '0;
    end else begin
      if (cfg_we) begin
        wheel_base <= cfg_data;
      end
      unique case (state)
        S_IDLE: begin
          if (in_ch.valid) begin
            travel <= (sum + signed'(33'(sum[32]))) >>> 1;
            diff <= 33'(dr) - 33'(dl);
            quad <= hq[15:14];
            last_left <= in_ch.left_count;
            last_right <= in_ch.right_count;
            state <= S_ROT;
          end
        end
        S_ROT: begin
          if (cor_done) begin
            state <= S_MUL;
          end
        end
        S_MUL: begin
          px <= travel * signed'(cq[31:0]) + 64'sd8192;
          py <= travel * signed'(sq[31:0]) + 64'sd8192;
          state <= S_ADD;
        end
        S_ADD: begin
          acc_x <= acc_x + PosW'(px >>> 14);
          acc_y <= acc_y + PosW'(py >>> 14);
          state <= S_VEC;
        end
        S_VEC: begin
          if (cor_done) begin
            acc_heading <= acc_heading + zr[31:16];
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_ch.ready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_busy_no_ready: assert property (@(posedge clk) disable iff (rst)
    state != S_IDLE |-> !in_ch.ready) else $error("ready while busy");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && !out_ch.ready |=> $stable(acc_heading) && out_ch.valid)
    else $error("result changed while stalled");
  a_accept_go: assert property (@(posedge clk) disable iff (rst)
    in_ch.valid && in_ch.ready |=> state == S_ROT) else $error("accept lost");
endmodule

>>> tb/sv/odometry_scoreboard.sv
// Scoreboard class that predicts the odometry pose and checks each result word.
`timescale 1ns / 1ps
class odometry_scoreboard;
  typedef struct {
    logic [47:0] pos_x;
    logic [47:0] pos_y;
    logic [15:0] heading;
  } pose_t;

  pose_t pending[$];
  logic [31:0] last_left, last_right;
  logic [47:0] acc_x, acc_y;
  logic [15:0] acc_heading;
  logic [15:0] wheel_base;
  int mismatches;

  function new();
    last_left = '0;
    last_right = '0;
    acc_x = '0;
    acc_y = '0;
    acc_heading = '0;
    wheel_base = ddo_pkg::WheelBaseReset;
    mismatches = 0;
  endfunction

  function void set_wheel_base(logic [15:0] v);
    wheel_base = v;
  endfunction

  function longint angle_step(int i);
    longint t[24];
    t = '{64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43,
          64'h0145D7E1, 64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F,
          64'h000A2F98, 64'h000517CC, 64'h00028BE6, 64'h000145F3, 64'h0000A2FA,
          64'h0000517D, 64'h000028BE, 64'h0000145F, 64'h00000A30, 64'h00000518,
          64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051};
    return t[i];
  endfunction

  function void note_sample(logic [31:0] left, logic [31:0] right);
    longint dl, dr, travel, diff, r, cx, sy, cq, sq, vx, vy, z, xs, ys, dh, px, py;
    logic [31:0] ud_l, ud_r;
    int q;
    pose_t p;
    ud_l = left - last_left;
    ud_r = right - last_right;
    dl = longint'($signed(ud_l));
    dr = longint'($signed(ud_r));
    travel = (dl + dr) / 2;
    diff = dr - dl;
    q = ((int'(acc_heading) + 8192) >> 14) & 3;
    r = longint'(acc_heading) - q * 16384;
    if (r >= 32768) r -= 65536;
    cx = 652032874;
    sy = 0;
    z = r * 65536;
    for (int i = 0; i < ddo_pkg::NStages; i++) begin
      xs = cx >>> i;
      ys = sy >>> i;
      if (z >= 0) begin
        cx -= ys; sy += xs; z -= angle_step(i);
      end else begin
        cx += ys; sy -= xs; z += angle_step(i);
      end
    end
    case (q)
      0: begin cq = cx; sq = sy; end
      1: begin cq = -sy; sq = cx; end
      2: begin cq = -cx; sq = -sy; end
      default: begin cq = sy; sq = -cx; end
    endcase
    px = (travel * cq + 8192) >>> 14;
    py = (travel * sq + 8192) >>> 14;
    acc_x = acc_x + px[47:0];
    acc_y = acc_y + py[47:0];
    vx = longint'(wheel_base) * 16777216;
    vy = diff * 16777216;
    z = 0;
    for (int i = 0; i < ddo_pkg::NStages; i++) begin
      xs = vx >>> i;
      ys = vy >>> i;
      if (vy >= 0) begin
        vx += ys; vy -= xs; z += angle_step(i);
      end else begin
        vx -= ys; vy += xs; z -= angle_step(i);
      end
    end
    dh = (z + 32768) >>> 16;
    acc_heading = acc_heading + dh[15:0];
    last_left = left;
    last_right = right;
    p.pos_x = acc_x;
    p.pos_y = acc_y;
    p.heading = acc_heading;
    pending.push_back(p);
  endfunction

  function void check_pose(logic [47:0] x, logic [47:0] y, logic [15:0] h);
    pose_t e;
    if (pending.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("Unexpected result word x=%h y=%h h=%h", x, y, h);
      return;
    end
    e = pending.pop_front();
    if (x !== e.pos_x || y !== e.pos_y || h !== e.heading) begin
      mismatches++;
      if (mismatches <= 10)
        $display("Pose mismatch: expected x=%h y=%h h=%h, got x=%h y=%h h=%h",
                 e.pos_x, e.pos_y, e.heading, x, y, h);
    end
  endfunction
endclass

>>> tb/sv/testbench.sv
// Top-level testbench for the differential drive odometry block.
`timescale 1ns / 1ps
module testbench;
  import ddo_pkg::*;

  logic clk, rst, cfg_we;
  logic [WbW-1:0] cfg_data;
  longint cycles;
  logic [31:0] cur_left, cur_right;
  odometry_scoreboard pose_board;

  ddo_in_if in_ch();
  ddo_out_if out_ch();

  differential_drive_odometry u_top (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_data(cfg_data),
    .in_ch(in_ch), .out_ch(out_ch)
  );

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  function automatic int gap_len();
    if ($urandom_range(0, 3) == 0) return 0;
    if ($urandom_range(0, 19) == 0) return $urandom_range(20, 120);
    return $urandom_range(0, 3);
  endfunction

  task automatic send_sample(logic [31:0] left, logic [31:0] right);
    in_ch.valid <= 1'b1;
    in_ch.left_count <= left;
    in_ch.right_count <= right;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    pose_board.note_sample(left, right);
    cur_left = left;
    cur_right = right;
    repeat (gap_len()) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  task automatic send_delta(longint dl, longint dr);
    send_sample(cur_left + dl[31:0], cur_right + dr[31:0]);
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (pose_board.pending.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic write_wheel_base(logic [15:0] v);
    cfg_we <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    pose_board.set_wheel_base(v);
  endtask

  task automatic random_phase(int n, int maxstep);
    int kind;
    for (int i = 0; i < n; i++) begin
      kind = $urandom_range(0, 9);
      if (kind < 6)
        send_delta($urandom_range(0, 2 * maxstep) - maxstep,
                   $urandom_range(0, 2 * maxstep) - maxstep);
      else if (kind < 8)
        send_delta($urandom_range(0, 2 * maxstep) - maxstep, 0);
      else
        send_sample($urandom, $urandom);
    end
  endtask

  initial begin
    pose_board = new();
    cur_left = '0;
    cur_right = '0;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_data = '0;
    in_ch.valid = 1'b0;
    in_ch.left_count = '0;
    in_ch.right_count = '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_delta(0, 0);
    send_delta(100, 100);
    send_delta(0, 300);
    send_delta(-200, 50);
    send_sample(32'h7FFFFFFF, 32'h80000000);
    send_sample(32'h80000000, 32'h7FFFFFFF);
    send_sample(32'hFFFFFFFF, 32'h00000001);
    send_sample(32'h00000001, 32'hFFFFFFFF);
    for (int i = 0; i < 6; i++) send_delta(-1000, 1000);
    for (int i = 0; i < 6; i++) send_delta(1000, -1000);
    wait_drained();
    write_wheel_base(16'd0);
    send_delta(0, 5);
    send_delta(5, 0);
    send_delta(7, 7);
    wait_drained();
    write_wheel_base(16'hFFFF);
    send_delta(-65535, 65535);
    send_delta(2000000000, 2000000000);
    send_delta(2000000000, 2000000000);
    send_delta(-2147483648, -2147483648);
    send_delta(-2147483648, -2147483647);
    wait_drained();

    write_wheel_base(16'd1);
    random_phase(400, 40);
    wait_drained();
    write_wheel_base(16'd408);
    random_phase(500, 5000);
    wait_drained();
    write_wheel_base(16'(($urandom_range(1, 65535))));
    random_phase(400, 100000);
    wait_drained();
    write_wheel_base(16'hFFFF);
    random_phase(300, 70000);
    wait_drained();
    write_wheel_base(16'd0);
    random_phase(300, 1000);
    wait_drained();

    if (pose_board.mismatches == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (out_ch.valid && out_ch.ready)
        pose_board.check_pose(out_ch.pos_x, out_ch.pos_y, out_ch.heading);
      if ($urandom_range(0, 2) == 0) out_ch.ready <= 1'b1;
      else out_ch.ready <= (gap_len() == 0);
    end
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > 2000000) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end
endmodule
